// ===== rtl/rigid_transform_pinhole_project_assert.svh =====
// assertion macros for the checker file rtp_checker.sv
// each macro samples on clk; all but RTP_ASSERT_RST are disabled while rst_n is low
`ifndef RIGID_TRANSFORM_PINHOLE_PROJECT_ASSERT_SVH
`define RIGID_TRANSFORM_PINHOLE_PROJECT_ASSERT_SVH

// same-cycle implication, outside reset
`define RTP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtp assertion failed");

// next-cycle implication, outside reset
`define RTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtp assertion failed");

// next-cycle implication, reset included
`define RTP_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rtp assertion failed");

`endif

// ===== rtl/rtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_pkg
// types, constants and codes shared by the projection pipeline
// ----------------------------------------------------------------------------
package rtp_pkg;

  // widths
  localparam int POS_W  = 24;
  localparam int CRD_W  = 27;
  localparam int CFG_W  = 20;
  localparam int NUM_W  = 47;
  localparam int DEN_W  = 34;
  localparam int QB     = 17;

  // register indexes
  localparam logic [1:0] REG_FOCAL_X  = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] REG_CENTER_X = 2'd2;
  localparam logic [1:0] REG_CENTER_Y = 2'd3;

  localparam logic [CFG_W-1:0] FOCAL_X_RST  = 20'd134400;
  localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 20'd134400;
  localparam logic [CFG_W-1:0] CENTER_X_RST = 20'd81920;
  localparam logic [CFG_W-1:0] CENTER_Y_RST = 20'd61440;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD_Z = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  // rotation in Q2.20, translation in 1/65536 m
  localparam logic signed [21:0] ROT_Q20 [3][3] = '{
    '{ 22'sd1048415,  22'sd1325,    -22'sd18337  },
    '{ -22'sd1550,    22'sd1048496, -22'sd12847  },
    '{ 22'sd18319,    22'sd12872,    22'sd1048337 }
  };
  localparam logic signed [CRD_W-1:0] TRANS [3] = '{
    27'sd1310, -27'sd49, -27'sd715
  };
  localparam logic signed [47:0] HALF_Q20 = 48'sd524288;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pixel_col;
    logic signed [15:0] pixel_row;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } xyz_t;

  // one lane of the divider
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic             bad_z;
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QB-1:0]    quo;
  } div_t;

endpackage

// ===== rtl/rtp_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_xform
// rotate and translate one point, two register stages
// ----------------------------------------------------------------------------
module rtp_xform (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  rtp_pkg::in_t  in_pt,
  output logic          out_vld,
  output rtp_pkg::xyz_t out_xyz
);
  import rtp_pkg::*;

  logic signed [45:0]      prod_r [3][3];
  logic signed [45:0]      prod_nxt [3][3];
  logic                    vld1_r, vld2_r;
  logic signed [POS_W-1:0] p [3];
  logic signed [CRD_W-1:0] c_nxt [3];
  logic signed [47:0]      acc [3];
  xyz_t                    xyz_r;

  // nine constant products
  always_comb begin
    p[0] = in_pt.pos_x;
    p[1] = in_pt.pos_y;
    p[2] = in_pt.pos_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[i][j] = 46'(ROT_Q20[i][j]) * 46'(p[j]);
      end
    end
  end

  // row sums, round to whole units, add translation
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 48'(prod_r[i][0]) + 48'(prod_r[i][1]) + 48'(prod_r[i][2]) + HALF_Q20;
      c_nxt[i] = acc[i][46:20] + TRANS[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      xyz_r.x <= c_nxt[0];
      xyz_r.y <= c_nxt[1];
      xyz_r.z <= c_nxt[2];
    end
  end

  assign out_vld = vld2_r;
  assign out_xyz = xyz_r;

endmodule

// ===== rtl/rtp_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_scale
// focal scaling, divisor set-up and quotient range check
// ----------------------------------------------------------------------------
module rtp_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  rtp_pkg::xyz_t              in_xyz,
  input  logic [rtp_pkg::CFG_W-1:0]  focal_x,
  input  logic [rtp_pkg::CFG_W-1:0]  focal_y,
  output logic                       out_vld,
  output rtp_pkg::div_t              out_col,
  output rtp_pkg::div_t              out_row
);
  import rtp_pkg::*;

  logic             vld_r;
  div_t             col_r, row_r, col_nxt, row_nxt;
  logic             bad_z;
  logic [DEN_W-1:0] den;

  function automatic div_t lane(input logic signed [CRD_W-1:0] c,
                                input logic [CFG_W-1:0] focal,
                                input logic [DEN_W-1:0] d,
                                input logic bz);
    div_t             r;
    logic [CRD_W-1:0] mag;
    logic [NUM_W-1:0] num;
    mag = c[CRD_W-1] ? CRD_W'(-c) : CRD_W'(c);
    num = NUM_W'(mag) * NUM_W'(focal);
    r.neg   = c[CRD_W-1];
    r.ovf   = (34'(num[NUM_W-1:QB]) >= d);
    r.bad_z = bz;
    r.rem   = num;
    r.den   = d;
    r.quo   = '0;
    return r;
  endfunction

  // depth check and divisor z * 256
  always_comb begin
    bad_z   = in_xyz.z[CRD_W-1] || (in_xyz.z == '0);
    den     = {in_xyz.z[25:0], 8'h00};
    col_nxt = lane(in_xyz.x, focal_x, den, bad_z);
    row_nxt = lane(in_xyz.y, focal_y, den, bad_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_col = col_r;
  assign out_row = row_r;

endmodule

// ===== rtl/rtp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_div
// restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module rtp_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  rtp_pkg::div_t in_d,
  output logic          out_vld,
  output rtp_pkg::div_t out_d
);
  import rtp_pkg::*;

  div_t stg_r [QB];
  div_t stg_nxt [QB];
  div_t src [QB];
  logic vld_r [QB];

  // one trial subtraction per stage, msb first
  always_comb begin
    logic [50:0] den_sh;
    logic [50:0] rem_x;
    src[0] = in_d;
    for (int k = 1; k < QB; k++) begin
      src[k] = stg_r[k-1];
    end
    for (int k = 0; k < QB; k++) begin
      stg_nxt[k] = src[k];
      den_sh = 51'(src[k].den) << (QB - 1 - k);
      rem_x  = 51'(src[k].rem);
      if (rem_x >= den_sh) begin
        stg_nxt[k].rem = src[k].rem - den_sh[NUM_W-1:0];
        stg_nxt[k].quo[QB-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QB; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < QB; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld = vld_r[QB-1];
  assign out_d   = stg_r[QB-1];

endmodule

// ===== rtl/rigid_transform_pinhole_project.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_transform_pinhole_project
// rigid transform of a 3D point and pinhole projection to pixels
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall / in_data carry one point per request
//   result channel: out_valid / out_stall / out_data carry one pixel result
//   configuration: cfg_wr_en, cfg_index, cfg_wdata write focal and centre
//   registers; write them only while no request is in flight
// pipeline: an accepted point passes 2 transform stages, 1 scaling stage,
//   17 divider stages and 1 output stage before its result is on out_valid
// throughput: one point per cycle unless a stalled result holds the pipeline,
//   as the one-bit-per-stage divider takes a new quotient every cycle
// reset: rst_n low clears every valid bit and reloads the register defaults
// stall: while out_valid is high and out_stall is high the whole pipeline
//   holds, in_stall goes high, and nothing is lost or repeated
// ----------------------------------------------------------------------------
module rigid_transform_pinhole_project (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rtp_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rtp_pkg::out_t             out_data,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [rtp_pkg::CFG_W-1:0] cfg_wdata
);
  import rtp_pkg::*;

  typedef struct packed {
    logic signed [15:0] pix;
    logic               sat;
  } pix_t;

  logic [CFG_W-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic             adv;
  logic             xf_vld, sc_vld, dv_vld, dv_vld_row;
  xyz_t             xf_xyz;
  div_t             sc_col, sc_row, dv_col, dv_row;
  logic             out_valid_r;
  out_t             out_r, out_nxt;
  pix_t             pc, pr;

  // whole pipeline moves unless a held result is stalled
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= FOCAL_X_RST;
      focal_y_r  <= FOCAL_Y_RST;
      center_x_r <= CENTER_X_RST;
      center_y_r <= CENTER_Y_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x_r  <= cfg_wdata;
        REG_FOCAL_Y:  focal_y_r  <= cfg_wdata;
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  rtp_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_valid),
    .in_pt   (in_data),
    .out_vld (xf_vld),
    .out_xyz (xf_xyz)
  );

  rtp_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (xf_vld),
    .in_xyz  (xf_xyz),
    .focal_x (focal_x_r),
    .focal_y (focal_y_r),
    .out_vld (sc_vld),
    .out_col (sc_col),
    .out_row (sc_row)
  );

  rtp_div u_div_col (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (sc_vld),
    .in_d    (sc_col),
    .out_vld (dv_vld),
    .out_d   (dv_col)
  );

  rtp_div u_div_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (sc_vld),
    .in_d    (sc_row),
    .out_vld (dv_vld_row),
    .out_d   (dv_row)
  );

  // signed quotient, add centre, truncate toward zero, clamp
  function automatic pix_t axis_pix(input div_t d, input logic [CFG_W-1:0] center);
    pix_t               r;
    logic [QB:0]        q_mag;
    logic signed [18:0] q;
    logic [27:0]        s;
    logic [27:0]        sm;
    logic signed [20:0] p;
    q_mag = d.ovf ? {1'b1, {QB{1'b0}}} : {1'b0, d.quo};
    q     = d.neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    s     = {q[18], q, 8'h00} + {8'h00, center};
    sm    = -s;
    if (s[27]) begin
      p = -$signed({1'b0, sm[27:8]});
    end else begin
      p = $signed({1'b0, s[27:8]});
    end
    if (p > 21'sd32767) begin
      r.pix = 16'sh7fff;
      r.sat = 1'b1;
    end else if (p < -21'sd32768) begin
      r.pix = -16'sh8000;
      r.sat = 1'b1;
    end else begin
      r.pix = p[15:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // result assembly
  always_comb begin
    pc = axis_pix(dv_col, center_x_r);
    pr = axis_pix(dv_row, center_y_r);
    if (dv_col.bad_z) begin
      out_nxt.pixel_col = '0;
      out_nxt.pixel_row = '0;
      out_nxt.status    = STATUS_BAD_Z;
    end else begin
      out_nxt.pixel_col = pc.pix;
      out_nxt.pixel_row = pr.pix;
      out_nxt.status    = (pc.sat || pr.sat) ? STATUS_SAT : STATUS_OK;
    end
  end

  // output register, both lanes run in lock step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld && dv_vld_row;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/rtp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_checker
// port-level checks on the projection block, bound to the top level
// ----------------------------------------------------------------------------
`include "rigid_transform_pinhole_project_assert.svh"

module rtp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input rtp_pkg::in_t              in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input rtp_pkg::out_t             out_data,
  input logic                      cfg_wr_en,
  input logic [1:0]                cfg_index,
  input logic [rtp_pkg::CFG_W-1:0] cfg_wdata
);
  import rtp_pkg::*;

  // a stalled result is held
  `RTP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // input is held back only by a stalled result
  `RTP_ASSERT_IMPL(a_in_stall, 1'b1, in_stall == (out_valid && out_stall))
  // a depth failure carries zero pixels
  `RTP_ASSERT_IMPL(a_bad_z_zero, out_valid && (out_data.status == STATUS_BAD_Z),
                   (out_data.pixel_col == 16'sd0) && (out_data.pixel_row == 16'sd0))
  // no undefined status code
  `RTP_ASSERT_IMPL(a_status_code, out_valid, out_data.status != 2'd3)
  // reset empties the pipeline
  `RTP_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind rigid_transform_pinhole_project rtp_checker u_rtp_checker (.*);

// ===== dv/rigid_transform_pinhole_project_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_transform_pinhole_project_test
// drives 3D points through the transform and projection block, predicts each
// pixel result in the bench and checks it field by field, under idling and
// stalling on both channels and across several focal and centre settings
// ----------------------------------------------------------------------------
module rigid_transform_pinhole_project_test;
  import rtp_pkg::*;

  localparam int LATENCY   = 21;
  localparam int WDOG_MAX  = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = REG_FOCAL_X;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // bench copy of the registers
  logic [CFG_W-1:0] fx_q, fy_q, cx_q, cy_q;

  out_t pixel_queue[$];
  int errors = 0;
  int n_points = 0;
  int n_results = 0;
  int n_bad_z = 0;
  int n_sat = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int wdog = 0;

  rigid_transform_pinhole_project dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // rotation and translation constants, kept locally
  function automatic longint rot_coef(int r, int c);
    longint m[9];
    m = '{1048415, 1325, -18337, -1550, 1048496, -12847, 18319, 12872, 1048337};
    return m[r*3+c];
  endfunction

  function automatic longint axis_pixel(longint c, longint z, longint f, longint ctr,
                                        ref bit sat);
    longint q, p;
    q = (c * f) / (z * 256);
    p = (q * 256 + ctr) / 256;
    if (p > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (p < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return p;
  endfunction

  function automatic out_t project_point(in_t pt);
    longint p[3];
    longint t[3];
    longint tr[3];
    longint acc;
    bit sat;
    out_t r;
    tr = '{1310, -49, -715};
    p[0] = longint'(pt.pos_x);
    p[1] = longint'(pt.pos_y);
    p[2] = longint'(pt.pos_z);
    sat = 1'b0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      acc = 524288;
      for (int j = 0; j < 3; j++) acc += rot_coef(i, j) * p[j];
      t[i] = (acc >>> 20) + tr[i];
    end
    if (t[2] <= 0) begin
      r.status = STATUS_BAD_Z;
    end else begin
      r.pixel_col = 16'(axis_pixel(t[0], t[2], longint'(fx_q), longint'(cx_q), sat));
      r.pixel_row = 16'(axis_pixel(t[1], t[2], longint'(fy_q), longint'(cy_q), sat));
      r.status = sat ? STATUS_SAT : STATUS_OK;
    end
    return r;
  endfunction

  // receiver stall and watchdog
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        want = pixel_queue.pop_front();
        n_results++;
        if (out_data.pixel_col !== want.pixel_col) begin
          $error("pixel_col expected %0d actual %0d", want.pixel_col, out_data.pixel_col);
          errors++;
        end
        if (out_data.pixel_row !== want.pixel_row) begin
          $error("pixel_row expected %0d actual %0d", want.pixel_row, out_data.pixel_row);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  // send one point, predicting its result on acceptance
  task automatic send_point(in_t pt);
    out_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = project_point(pt);
    pixel_queue.push_back(r);
    n_points++;
    if (r.status == STATUS_BAD_Z) n_bad_z++;
    if (r.status == STATUS_SAT) n_sat++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one register write, enable left high for a following write
  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_FOCAL_X:  fx_q = val;
      REG_FOCAL_Y:  fy_q = val;
      REG_CENTER_X: cx_q = val;
      REG_CENTER_Y: cy_q = val;
      default:      ;
    endcase
  endtask

  task automatic set_camera(logic [CFG_W-1:0] fx, logic [CFG_W-1:0] fy,
                            logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic in_t mk(int x, int y, int z);
    in_t p;
    p.pos_x = x[23:0];
    p.pos_y = y[23:0];
    p.pos_z = z[23:0];
    return p;
  endfunction

  // random point: mostly realistic depths, some shallow, some full-range noise
  function automatic in_t rand_point();
    in_t p;
    int k;
    k = $urandom_range(9);
    p.pos_x = 24'($urandom);
    p.pos_y = 24'($urandom);
    p.pos_z = 24'($urandom);
    if (k < 6) begin
      p.pos_z = 24'($urandom_range(8388607, 20000));
      p.pos_x = 24'(int'($urandom_range(400000)) - 200000);
      p.pos_y = 24'(int'($urandom_range(400000)) - 200000);
    end else if (k < 8) begin
      p.pos_z = 24'($urandom_range(3000));
    end
    return p;
  endfunction

  // extremes, depth not positive, saturation and the zero point
  task automatic test_directed();
    send_point(mk(0, 0, 0));
    send_point(mk(0, 0, 65536));
    send_point(mk(8388607, 8388607, 8388607));
    send_point(mk(-8388608, -8388608, -8388608));
    send_point(mk(-8388608, 8388607, 8388607));
    send_point(mk(8388607, -8388608, 8388607));
    send_point(mk(0, 0, 715));
    send_point(mk(0, 0, 716));
    send_point(mk(0, 0, 717));
    send_point(mk(8388607, 8388607, 1000));
    send_point(mk(-8388608, -8388608, 1000));
    send_point(mk(65536, -65536, 131072));
    send_point(mk(-100000, 100000, 200000));
    send_point(mk(0, 0, -1));
    send_point(mk(1, -1, 8388607));
    send_point(mk(-5592405, 5592405, 2796202));
    drain();
  endtask

  task automatic test_random(int count, int ip, int sp);
    idle_pct = ip;
    stall_pct = sp;
    for (int i = 0; i < count; i++) send_point(rand_point());
    idle_pct = 0;
    drain();
    stall_pct = 0;
  endtask

  initial begin
    fx_q = FOCAL_X_RST;
    fy_q = FOCAL_Y_RST;
    cx_q = CENTER_X_RST;
    cy_q = CENTER_Y_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults first
    test_directed();
    test_random(300, 0, 0);
    set_camera(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    test_directed();
    test_random(300, 59, 0);
    set_camera('0, '0, '0, '0);
    test_directed();
    test_random(200, 0, 59);
    set_camera(20'd1, 20'd256, 20'd128, 20'hFFFFF);
    test_random(300, 25, 25);
    for (int c = 0; c < 3; c++) begin
      set_camera(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      test_random(250, (c == 1) ? 59 : 25, (c == 2) ? 59 : 25);
    end
    set_camera(FOCAL_X_RST, FOCAL_Y_RST, CENTER_X_RST, CENTER_Y_RST);
    test_random(150, 0, 0);

    $display("covered %0d points, %0d results checked (%0d bad depth, %0d saturated)",
             n_points, n_results, n_bad_z, n_sat);
    $display("over eight camera settings with idling and stalling on both channels");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
